FILE: hdl/hrhp_pkg.sv
// Shared types and constants of the HTTP response header parser.
package hrhp_pkg;

   localparam int MAX_CONTENT_LENGTH_DEF = 65536;
   localparam int MAX_BUFFERED_DEF       = 131072;
   localparam int WIN                    = 15;
   localparam int QUEUE_DEPTH            = 4;

   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_CLOSE   = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RES_INCOMPLETE = 2'd0,
      RES_COMPLETE   = 2'd1,
      RES_MALFORMED  = 2'd2,
      RES_OVERFLOW   = 2'd3
   } result_type;

   typedef enum logic [5:0] {
      PH_PROTO  = 6'b000001,
      PH_SPACE  = 6'b000010,
      PH_DIGITS = 6'b000100,
      PH_GOOD   = 6'b001000,
      PH_BAD    = 6'b010000,
      PH_BODY   = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      LEN_NONE   = 4'b0001,
      LEN_SPACES = 4'b0010,
      LEN_DIGITS = 4'b0100,
      LEN_DONE   = 4'b1000
   } len_phase_type;

   // Progress through the Connection value; each letter state names what is matched.
   typedef enum logic [6:0] {
      CONN_NONE   = 7'b0000001,
      CONN_SPACES = 7'b0000010,
      CONN_C      = 7'b0000100,
      CONN_CL     = 7'b0001000,
      CONN_CLO    = 7'b0010000,
      CONN_CLOS   = 7'b0100000,
      CONN_DONE   = 7'b1000000
   } conn_phase_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      mode_type   mode;
      logic [7:0] data_byte;
      logic       is_digit;
      logic [3:0] digit;
      logic [7:0] folded;
      logic       is_space;
   } item_type;

   typedef struct packed {
      result_type  parse_result;
      logic [9:0]  status_code;
      logic        keep_alive;
      logic [17:0] header_length;
      logic [17:0] body_length;
      logic        is_body_byte;
   } result_rec_type;

   function automatic logic [7:0] fold(input logic [7:0] b);
      fold = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

endpackage

FILE: hdl/hrhp_front.sv
// Front end: accepts bytes, classifies them and queues them for the back end.
module hrhp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_mode,
   input  logic [7:0]         in_byte,
   output logic               q_valid,
   input  logic               q_ready,
   output hrhp_pkg::item_type q_item
);
   localparam int AW = $clog2(hrhp_pkg::QUEUE_DEPTH);

   hrhp_pkg::item_type mem_ff [hrhp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   hrhp_pkg::item_type cls;
   logic push, pop;

   always_comb begin
      cls.mode      = hrhp_pkg::mode_type'(in_mode);
      cls.data_byte = in_byte;
      cls.is_digit  = in_byte >= 8'h30 && in_byte <= 8'h39;
      cls.digit     = 4'(in_byte - 8'h30);
      cls.folded    = hrhp_pkg::fold(in_byte);
      cls.is_space  = in_byte == 8'h20;
   end

   assign in_ready = cnt_ff != (AW+1)'(hrhp_pkg::QUEUE_DEPTH);
   assign q_valid  = cnt_ff != '0;
   assign q_item   = mem_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= cls;
      end
   end
endmodule

FILE: hdl/hrhp_back.sv
// Back end: header scanning, length tracking and result register.
module hrhp_back #(
   parameter int MAX_CONTENT_LENGTH = hrhp_pkg::MAX_CONTENT_LENGTH_DEF,
   parameter int MAX_BUFFERED       = hrhp_pkg::MAX_BUFFERED_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  hrhp_pkg::item_type        q_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output hrhp_pkg::result_rec_type  out_rec
);
   localparam int LW = $clog2(MAX_CONTENT_LENGTH + 2);
   localparam int CW = $clog2(MAX_BUFFERED + 1);
   localparam int DW = ((LW > CW) ? LW : CW) + 1;

   logic [7:0] win_ff [hrhp_pkg::WIN];
   logic [7:0] win_in [hrhp_pkg::WIN];
   logic [CW-1:0] cnt_ff, cnt_in, hdr_ff, hdr_in;
   hrhp_pkg::phase_type ph_ff, ph_in;
   logic [9:0] st_ff, st_in;
   logic [2:0] sdi_ff, sdi_in;
   hrhp_pkg::len_phase_type lp_ff, lp_in;
   logic [LW-1:0] lv_ff, lv_in;
   hrhp_pkg::conn_phase_type cp_ff, cp_in;
   logic ka_ff, ka_in;
   hrhp_pkg::result_type res_ff, res_in;
   logic body_flag;
   logic [LW+3:0] lv_mul;
   logic [CW-1:0] body_cnt;
   logic [7:0] b, c;
   logic len_match, conn_match, term_match;
   logic take;
   hrhp_pkg::result_rec_type rec_ff, rec_in;
   logic ov_ff;

   localparam logic [7:0] PROTO [5] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};
   localparam logic [7:0] CLOSE [5] = '{8'h63, 8'h6C, 8'h6F, 8'h73, 8'h65};
   localparam logic [7:0] LEN_NAME [15] = '{8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65,
      8'h6E, 8'h74, 8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A};
   localparam logic [7:0] CONN_NAME [11] = '{8'h63, 8'h6F, 8'h6E, 8'h6E, 8'h65,
      8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h3A};

   assign q_ready = !ov_ff || out_ready;
   assign take    = q_valid && q_ready;
   assign b       = q_item.data_byte;
   assign c       = q_item.folded;

   always_comb begin
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      hdr_in   = hdr_ff;
      ph_in    = ph_ff;
      st_in    = st_ff;
      sdi_in   = sdi_ff;
      lp_in    = lp_ff;
      lv_in    = lv_ff;
      cp_in    = cp_ff;
      ka_in    = ka_ff;
      res_in   = res_ff;
      body_flag = 1'b0;
      lv_mul   = '0;
      len_match = 1'b0;
      conn_match = 1'b0;
      term_match = 1'b0;
      case (q_item.mode)
         hrhp_pkg::MODE_RESTART: begin
            for (int i = 0; i < hrhp_pkg::WIN; i++) win_in[i] = '0;
            cnt_in = '0;
            hdr_in = '0;
            ph_in  = hrhp_pkg::PH_PROTO;
            st_in  = '0;
            sdi_in = '0;
            lp_in  = hrhp_pkg::LEN_NONE;
            lv_in  = '0;
            cp_in  = hrhp_pkg::CONN_NONE;
            ka_in  = 1'b1;
            res_in = hrhp_pkg::RES_INCOMPLETE;
         end
         hrhp_pkg::MODE_BYTE: begin
            if (res_ff == hrhp_pkg::RES_INCOMPLETE) begin
               if (cnt_ff >= CW'(MAX_BUFFERED)) begin
                  res_in = hrhp_pkg::RES_OVERFLOW;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  if (ph_ff == hrhp_pkg::PH_BODY) begin
                     body_flag = 1'b1;
                     if (lp_ff != hrhp_pkg::LEN_NONE &&
                         DW'(cnt_in - hdr_ff) >= DW'(lv_ff))
                        res_in = hrhp_pkg::RES_COMPLETE;
                  end else begin
                     // Status line.
                     case (ph_ff)
                        hrhp_pkg::PH_PROTO: begin
                           if (sdi_ff < 3'd5 && b == PROTO[sdi_ff]) begin
                              if (sdi_ff == 3'd4) begin
                                 ph_in  = hrhp_pkg::PH_SPACE;
                                 sdi_in = '0;
                              end else begin
                                 sdi_in = sdi_ff + 1'b1;
                              end
                           end else begin
                              ph_in = hrhp_pkg::PH_BAD;
                           end
                        end
                        hrhp_pkg::PH_SPACE: if (q_item.is_space) ph_in = hrhp_pkg::PH_DIGITS;
                        hrhp_pkg::PH_DIGITS: begin
                           if (q_item.is_digit) begin
                              st_in  = 10'((st_ff << 3) + (st_ff << 1) + 10'(q_item.digit));
                              sdi_in = sdi_ff + 1'b1;
                              if (sdi_in >= 3'd3) ph_in = hrhp_pkg::PH_GOOD;
                           end else begin
                              ph_in = hrhp_pkg::PH_BAD;
                           end
                        end
                        default: ;
                     endcase
                     // Content length value.
                     if ((lp_ff == hrhp_pkg::LEN_SPACES || lp_ff == hrhp_pkg::LEN_DIGITS) &&
                         !(lp_ff == hrhp_pkg::LEN_SPACES && q_item.is_space)) begin
                        if (q_item.is_digit) begin
                           lv_mul = (LW+4)'(lv_ff) * (LW+4)'(10) + (LW+4)'(q_item.digit);
                           if (lv_mul > (LW+4)'(MAX_CONTENT_LENGTH))
                              lv_in = LW'(MAX_CONTENT_LENGTH + 1);
                           else
                              lv_in = LW'(lv_mul);
                           lp_in = hrhp_pkg::LEN_DIGITS;
                        end else begin
                           lp_in = hrhp_pkg::LEN_DONE;
                        end
                     end
                     // Connection value: leading spaces, then the letters of close.
                     case (cp_ff)
                        hrhp_pkg::CONN_SPACES: begin
                           if (!q_item.is_space)
                              cp_in = (c == CLOSE[0]) ? hrhp_pkg::CONN_C : hrhp_pkg::CONN_DONE;
                        end
                        hrhp_pkg::CONN_C:
                           cp_in = (c == CLOSE[1]) ? hrhp_pkg::CONN_CL : hrhp_pkg::CONN_DONE;
                        hrhp_pkg::CONN_CL:
                           cp_in = (c == CLOSE[2]) ? hrhp_pkg::CONN_CLO : hrhp_pkg::CONN_DONE;
                        hrhp_pkg::CONN_CLO:
                           cp_in = (c == CLOSE[3]) ? hrhp_pkg::CONN_CLOS : hrhp_pkg::CONN_DONE;
                        hrhp_pkg::CONN_CLOS: begin
                           if (c == CLOSE[4]) ka_in = 1'b0;
                           cp_in = hrhp_pkg::CONN_DONE;
                        end
                        default: ;
                     endcase
                     for (int i = 0; i < hrhp_pkg::WIN - 1; i++) win_in[i] = win_ff[i+1];
                     win_in[hrhp_pkg::WIN-1] = b;
                     len_match = 1'b1;
                     for (int i = 0; i < 15; i++)
                        if (hrhp_pkg::fold(win_in[i]) != LEN_NAME[i]) len_match = 1'b0;
                     conn_match = 1'b1;
                     for (int i = 0; i < 11; i++)
                        if (hrhp_pkg::fold(win_in[i+4]) != CONN_NAME[i]) conn_match = 1'b0;
                     term_match = win_in[11] == 8'h0D && win_in[12] == 8'h0A &&
                                  win_in[13] == 8'h0D && win_in[14] == 8'h0A;
                     if (lp_in == hrhp_pkg::LEN_NONE && len_match) lp_in = hrhp_pkg::LEN_SPACES;
                     if (cp_in == hrhp_pkg::CONN_NONE && conn_match)
                        cp_in = hrhp_pkg::CONN_SPACES;
                     if (term_match) begin
                        hdr_in = cnt_in;
                        if (ph_in != hrhp_pkg::PH_GOOD)
                           res_in = hrhp_pkg::RES_MALFORMED;
                        else if (lp_in != hrhp_pkg::LEN_NONE &&
                                 lv_in > LW'(MAX_CONTENT_LENGTH))
                           res_in = hrhp_pkg::RES_MALFORMED;
                        else if (lp_in != hrhp_pkg::LEN_NONE && lv_in == '0)
                           res_in = hrhp_pkg::RES_COMPLETE;
                        ph_in = hrhp_pkg::PH_BODY;
                     end
                  end
               end
            end
         end
         hrhp_pkg::MODE_CLOSE: begin
            if (res_ff == hrhp_pkg::RES_INCOMPLETE) begin
               if (ph_ff == hrhp_pkg::PH_BODY && lp_ff == hrhp_pkg::LEN_NONE) begin
                  res_in = hrhp_pkg::RES_COMPLETE;
                  ka_in  = 1'b0;
               end else begin
                  res_in = hrhp_pkg::RES_MALFORMED;
               end
            end
         end
         default: ;
      endcase
      body_cnt = (ph_in == hrhp_pkg::PH_BODY) ? cnt_in - hdr_in : '0;
      rec_in.parse_result  = res_in;
      rec_in.status_code   = st_in;
      rec_in.keep_alive    = ka_in;
      rec_in.header_length = 18'(hdr_in);
      rec_in.body_length   = 18'(body_cnt);
      rec_in.is_body_byte  = body_flag;
   end

   assign out_valid = ov_ff;
   assign out_rec   = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hrhp_pkg::WIN; i++) win_ff[i] <= '0;
         cnt_ff <= '0;
         hdr_ff <= '0;
         ph_ff  <= hrhp_pkg::PH_PROTO;
         st_ff  <= '0;
         sdi_ff <= '0;
         lp_ff  <= hrhp_pkg::LEN_NONE;
         lv_ff  <= '0;
         cp_ff  <= hrhp_pkg::CONN_NONE;
         ka_ff  <= 1'b1;
         res_ff <= hrhp_pkg::RES_INCOMPLETE;
         ov_ff  <= 1'b0;
      end else begin
         if (take) begin
            win_ff <= win_in;
            cnt_ff <= cnt_in;
            hdr_ff <= hdr_in;
            ph_ff  <= ph_in;
            st_ff  <= st_in;
            sdi_ff <= sdi_in;
            lp_ff  <= lp_in;
            lv_ff  <= lv_in;
            cp_ff  <= cp_in;
            ka_ff  <= ka_in;
            res_ff <= res_in;
         end
         if (take) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (take) rec_ff <= rec_in;
   end
endmodule

FILE: hdl/http_response_header_parser_unit.sv
// Top level of the HTTP/1.1 response header parser.
// An item passes the classification queue, then the combinational scan into the
// result register, which holds the queue back while its result is not taken.
// Throughput: one item per cycle while results are taken as they come.
// Reset: synchronous and active high; it empties the queue and the result
// register and puts the parser in the state of a fresh response.
module http_response_header_parser_unit #(
   parameter int MAX_CONTENT_LENGTH = hrhp_pkg::MAX_CONTENT_LENGTH_DEF,
   parameter int MAX_BUFFERED       = hrhp_pkg::MAX_BUFFERED_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // parse_result[1:0], status_code[11:2], keep_alive[12], header_length[30:13],
   // body_length[48:31], is_body_byte[49], zero fill to 56 bits
   output logic [55:0] rsp_tdata
);
   // Items pass from the classifying front end through a short queue.
   logic q_valid, q_ready;
   hrhp_pkg::item_type q_item;
   hrhp_pkg::result_rec_type rec;

   hrhp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mode(req_tuser), .in_byte(req_tdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   // The back end holds all parse state and the output register.
   hrhp_back #(
      .MAX_CONTENT_LENGTH(MAX_CONTENT_LENGTH), .MAX_BUFFERED(MAX_BUFFERED)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rec(rec)
   );

   assign rsp_tdata = {6'd0, rec.is_body_byte, rec.body_length, rec.header_length,
                       rec.keep_alive, rec.status_code, rec.parse_result};
endmodule

FILE: tb/tb_http_response_header_parser_unit.sv
// Testbench of the HTTP/1.1 response header parser: directed and random byte streams.
`timescale 1ns / 100ps

module tb_http_response_header_parser_unit;

   localparam int MAX_LEN = 65536;
   localparam int MAX_BUF = 131072;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   http_response_header_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: a private copy of the parser.
   logic [7:0]  hist [hrhp_pkg::WIN];
   int unsigned taken_bytes;
   hrhp_pkg::phase_type line_phase;
   int unsigned status_acc;
   int unsigned digit_idx;
   hrhp_pkg::len_phase_type len_phase;
   int unsigned len_acc;
   int unsigned conn_phase;
   bit          keep_flag;
   int unsigned hdr_offset;
   hrhp_pkg::result_type verdict;

   hrhp_pkg::result_rec_type expected_results[$];
   int mismatches = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_receiver = 1'b0;

   function automatic bit tail_is(string word, bit fold_case);
      int n;
      logic [7:0] c;
      n = word.len();
      for (int i = 0; i < n; i++) begin
         c = hist[hrhp_pkg::WIN - n + i];
         if (fold_case) c = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
         if (c != word[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void clear_parser();
      for (int i = 0; i < hrhp_pkg::WIN; i++) hist[i] = 8'd0;
      taken_bytes = 0; line_phase = hrhp_pkg::PH_PROTO; status_acc = 0; digit_idx = 0;
      len_phase = hrhp_pkg::LEN_NONE; len_acc = 0; conn_phase = 0; keep_flag = 1'b1;
      hdr_offset = 0; verdict = hrhp_pkg::RES_INCOMPLETE;
   endfunction

   function automatic bit digit_ok(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // Scans one header byte: status line, Content-Length, Connection, terminator.
   function automatic void scan_header_byte(logic [7:0] b);
      string proto;
      string closew;
      logic [7:0] c;
      proto = "HTTP/";
      closew = "close";
      c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      case (line_phase)
         hrhp_pkg::PH_PROTO: begin
            if (digit_idx < 5 && b == proto[digit_idx]) begin
               digit_idx++;
               if (digit_idx == 5) begin
                  line_phase = hrhp_pkg::PH_SPACE;
                  digit_idx = 0;
               end
            end else line_phase = hrhp_pkg::PH_BAD;
         end
         hrhp_pkg::PH_SPACE: if (b == " ") line_phase = hrhp_pkg::PH_DIGITS;
         hrhp_pkg::PH_DIGITS: begin
            if (digit_ok(b)) begin
               status_acc = (status_acc * 10 + (b - "0")) & 10'h3FF;
               digit_idx++;
               if (digit_idx >= 3) line_phase = hrhp_pkg::PH_GOOD;
            end else line_phase = hrhp_pkg::PH_BAD;
         end
         default: ;
      endcase
      if ((len_phase == hrhp_pkg::LEN_SPACES || len_phase == hrhp_pkg::LEN_DIGITS) &&
          !(len_phase == hrhp_pkg::LEN_SPACES && b == " ")) begin
         if (digit_ok(b)) begin
            len_acc = len_acc * 10 + (b - "0");
            if (len_acc > MAX_LEN) len_acc = MAX_LEN + 1;
            len_phase = hrhp_pkg::LEN_DIGITS;
         end else len_phase = hrhp_pkg::LEN_DONE;
      end
      if (conn_phase == 1) begin
         if (b != " ") conn_phase = (c == closew[0]) ? 2 : 7;
      end else if (conn_phase >= 2 && conn_phase <= 5) begin
         if (c == closew[conn_phase - 1]) begin
            if (conn_phase == 5) begin
               keep_flag = 1'b0;
               conn_phase = 7;
            end else conn_phase++;
         end else conn_phase = 7;
      end
      for (int i = 0; i < hrhp_pkg::WIN - 1; i++) hist[i] = hist[i + 1];
      hist[hrhp_pkg::WIN - 1] = b;
      if (len_phase == hrhp_pkg::LEN_NONE && tail_is("content-length:", 1'b1))
         len_phase = hrhp_pkg::LEN_SPACES;
      if (conn_phase == 0 && tail_is("connection:", 1'b1)) conn_phase = 1;
      if (tail_is("\r\n\r\n", 1'b0)) begin
         hdr_offset = taken_bytes;
         if (line_phase != hrhp_pkg::PH_GOOD) verdict = hrhp_pkg::RES_MALFORMED;
         else if (len_phase != hrhp_pkg::LEN_NONE && len_acc > MAX_LEN)
            verdict = hrhp_pkg::RES_MALFORMED;
         else if (len_phase != hrhp_pkg::LEN_NONE && len_acc == 0)
            verdict = hrhp_pkg::RES_COMPLETE;
         line_phase = hrhp_pkg::PH_BODY;
      end
   endfunction

   function automatic hrhp_pkg::result_rec_type predict_parse(hrhp_pkg::mode_type m,
                                                               logic [7:0] b);
      hrhp_pkg::result_rec_type r;
      bit body_flag;
      body_flag = 1'b0;
      if (m == hrhp_pkg::MODE_RESTART) clear_parser();
      else if (m == hrhp_pkg::MODE_BYTE && verdict == hrhp_pkg::RES_INCOMPLETE) begin
         if (taken_bytes >= MAX_BUF) verdict = hrhp_pkg::RES_OVERFLOW;
         else begin
            taken_bytes++;
            if (line_phase == hrhp_pkg::PH_BODY) begin
               body_flag = 1'b1;
               if (len_phase != hrhp_pkg::LEN_NONE && taken_bytes - hdr_offset >= len_acc)
                  verdict = hrhp_pkg::RES_COMPLETE;
            end else scan_header_byte(b);
         end
      end else if (m == hrhp_pkg::MODE_CLOSE && verdict == hrhp_pkg::RES_INCOMPLETE) begin
         if (line_phase == hrhp_pkg::PH_BODY && len_phase == hrhp_pkg::LEN_NONE) begin
            verdict = hrhp_pkg::RES_COMPLETE;
            keep_flag = 1'b0;
         end else verdict = hrhp_pkg::RES_MALFORMED;
      end
      r.parse_result = verdict;
      r.status_code = status_acc[9:0];
      r.keep_alive = keep_flag;
      r.header_length = hdr_offset[17:0];
      r.body_length = (line_phase == hrhp_pkg::PH_BODY) ?
                      18'(taken_bytes - hdr_offset) : 18'd0;
      r.is_body_byte = body_flag;
      return r;
   endfunction

   // Sends one item with random idle cycles before it; predicts on transfer.
   task automatic send_item(hrhp_pkg::mode_type m, logic [7:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_parse(m, b));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(hrhp_pkg::MODE_BYTE, s[i]);
   endtask

   task automatic send_body(int n);
      for (int i = 0; i < n; i++) send_item(hrhp_pkg::MODE_BYTE, 8'($urandom));
   endtask

   // Receiver: random stall, or held off entirely while hold_receiver is set.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      hrhp_pkg::result_rec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.parse_result  = hrhp_pkg::result_type'(rsp_tdata[1:0]);
         got.status_code   = rsp_tdata[11:2];
         got.keep_alive    = rsp_tdata[12];
         got.header_length = rsp_tdata[30:13];
         got.body_length   = rsp_tdata[48:31];
         got.is_body_byte  = rsp_tdata[49];
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got != want || rsp_tdata[55:50] != 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h, got %h (tdata %h)", want, got, rsp_tdata);
            end
         end
      end
   end

   // Stops offering items and waits until every predicted result has been checked.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Directed: good responses, bad status, big length, closes, mode 3, extremes.
   task automatic test_directed();
      send_item(hrhp_pkg::MODE_RESTART, 8'hFF);
      send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
      send_body(3);
      send_item(hrhp_pkg::MODE_BYTE, 8'h00);
      send_item(hrhp_pkg::MODE_CLOSE, 8'h00);
      send_item(hrhp_pkg::MODE_UNUSED, 8'hAA);
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTP/1.0 404 x\r\nCONNECTION: Close\r\n\r\n");
      send_body(2);
      send_item(hrhp_pkg::MODE_CLOSE, 8'h55);
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTX/1 999\r\n\r\n");
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTP/1.1 2x0\r\ncontent-length: 99999999\r\n\r\n");
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTP/1.1 204 N\r\nContent-Length:\r\n\r\n");
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTP/1.1 200");
      send_item(hrhp_pkg::MODE_CLOSE, 8'h00);
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
      send_text("HTTP/1.1 000 a\r\ncontent-length: 65536\r\n\r\n");
      send_body(40);
      send_item(hrhp_pkg::MODE_RESTART, 8'h00);
   endtask

   function automatic string rand_header();
      string s;
      string names [4];
      names = '{"Content-Length:", "content-LENGTH:", "Connection:", "X-A:"};
      s = $sformatf("HTTP/1.%0d %0d%0d%0d R\r\n", $urandom_range(1),
                    $urandom_range(9), $urandom_range(9), $urandom_range(9));
      for (int k = $urandom_range(3); k > 0; k--) begin
         case ($urandom_range(3))
            0: s = {s, names[$urandom_range(1)], "  ",
                    $sformatf("%0d", $urandom_range(12)), "\r\n"};
            1: s = {s, names[2], " ",
                    ($urandom_range(1) ? "cLoSe" : "keep-alive"), "\r\n"};
            2: s = {s, names[3], " v\r\n"};
            default: s = {s, names[$urandom_range(1)],
                          $sformatf("%0d", $urandom_range(70000)), "\r\n"};
         endcase
      end
      if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom);
      return {s, "\r\n"};
   endfunction

   // Random: mostly well-formed responses with random content, some noise.
   task automatic test_random(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         string h;
         h = rand_header();
         send_item(hrhp_pkg::MODE_RESTART, 8'($urandom));
         send_text(h);
         sent += h.len() + 1;
         case ($urandom_range(5))
            0: begin
               send_body(4);
               send_item(hrhp_pkg::MODE_CLOSE, 8'($urandom));
               sent += 5;
            end
            1: begin
               send_item(hrhp_pkg::mode_type'($urandom_range(3)), 8'($urandom));
               sent++;
            end
            default: begin send_body($urandom_range(14)); sent += 8; end
         endcase
      end
   endtask

   // Hold the receiver off for a long stretch so that the input stalls.
   task automatic test_backpressure();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (60) @(posedge clock);
            hold_receiver = 1'b0;
         end
         send_text("HTTP/1.1 301 M\r\nConnection: close\r\n\r\n");
      join
      drain();
   endtask

   initial begin
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      sender_idle_pct = 53; test_random(350); drain();
      sender_idle_pct = 0; receiver_stall_pct = 53; test_random(350); drain();
      sender_idle_pct = 10; receiver_stall_pct = 10; test_random(400); drain();
      sender_idle_pct = 0; receiver_stall_pct = 0; test_random(400);
      test_backpressure();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
hdl/hrhp_pkg.sv
hdl/hrhp_front.sv
hdl/hrhp_back.sv
hdl/http_response_header_parser_unit.sv
tb/tb_http_response_header_parser_unit.sv
